FILE: hdl/cdes_pkg.sv
// Shared types, codes and decode function for the CiA 402 drive enable sequencer.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package cdes_pkg;

  localparam int POSITION_WIDTH_DEF = 32;
  localparam int COUNT_WIDTH_DEF    = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_LOW       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_WAIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_MODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_THRESHOLD = 3'd4;

  // register reset values
  localparam logic [15:0]        HOLD_LOW_RST      = 16'd5;
  localparam logic [15:0]        RECOVERY_WAIT_RST = 16'd100;
  localparam logic [7:0]         MAX_ATTEMPTS_RST  = 8'd3;
  localparam logic signed [7:0]  TARGET_MODE_RST   = 8'sd8;
  localparam logic [30:0]        LOCK_THRESH_RST   = 31'd1000;

  localparam logic signed [7:0] MODE_CSV = 8'sd9;
  localparam logic signed [7:0] MODE_CST = 8'sd10;

  localparam logic [7:0] ATTEMPT_MAX = 8'hFF;

  // controlwords
  localparam logic [15:0] CW_ZERO       = 16'h0000;
  localparam logic [15:0] CW_VOLTAGE    = 16'h0002;
  localparam logic [15:0] CW_SHUTDOWN   = 16'h0006;
  localparam logic [15:0] CW_DISABLE_OP = 16'h0007;
  localparam logic [15:0] CW_ENABLE_OP  = 16'h000F;
  localparam logic [15:0] CW_RESET      = 16'h0080;

  // statusword masks and patterns
  localparam logic [15:0] SW_MASK_BASE   = 16'h004F;
  localparam logic [15:0] SW_MASK_RUN    = 16'h006F;
  localparam logic [15:0] SW_REACTION    = 16'h000F;
  localparam logic [15:0] SW_FAULT       = 16'h0008;
  localparam logic [15:0] SW_NOT_READY   = 16'h0000;
  localparam logic [15:0] SW_DISABLED    = 16'h0040;
  localparam logic [15:0] SW_READY       = 16'h0021;
  localparam logic [15:0] SW_SWITCHED_ON = 16'h0023;
  localparam logic [15:0] SW_ENABLED     = 16'h0027;
  localparam logic [15:0] SW_QUICK_STOP  = 16'h0007;

  typedef enum logic [2:0] {
    ST_NOT_READY   = 3'd0,
    ST_DISABLED    = 3'd1,
    ST_READY       = 3'd2,
    ST_SWITCHED_ON = 3'd3,
    ST_ENABLED     = 3'd4,
    ST_QUICK_STOP  = 3'd5,
    ST_REACTION    = 3'd6,
    ST_FAULT       = 3'd7
  } cdes_state_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HOLD = 3'd1,
    PH_EDGE = 3'd2,
    PH_WAIT = 3'd3,
    PH_PERM = 3'd4
  } cdes_phase_e;

  typedef struct packed {
    logic [15:0]        statusword;
    logic signed [7:0]  reported_mode;
    logic signed [31:0] measured_pos;
    logic signed [31:0] target_position;
    logic signed [31:0] target_velocity;
    logic signed [15:0] target_torque;
    logic               enable_request;
    logic               clear_attempts;
  } cdes_in_t;

  typedef struct packed {
    logic [15:0]        controlword;
    logic [2:0]         drive_state;
    logic               fault_flag;
    logic               operational;
    logic               position_locked;
    logic signed [31:0] safe_position;
    logic signed [31:0] safe_velocity;
    logic signed [15:0] safe_torque;
    logic [2:0]         reset_phase_out;
    logic [7:0]         attempts_out;
  } cdes_out_t;

  typedef struct packed {
    logic [15:0]       hold_low_cycles;
    logic [15:0]       recovery_wait_cycles;
    logic [7:0]        max_reset_attempts;
    logic signed [7:0] target_mode;
    logic [30:0]       lock_threshold;
  } cdes_cfg_t;

  // Base-mask checks (faults, not ready, disabled) first, run states on wider mask.
  function automatic cdes_state_e cdes_decode(logic [15:0] sw);
    logic [15:0] b;
    logic [15:0] r;
    b = sw & SW_MASK_BASE;
    r = sw & SW_MASK_RUN;
    if (b == SW_REACTION)         return ST_REACTION;
    else if (b == SW_FAULT)       return ST_FAULT;
    else if (b == SW_NOT_READY)   return ST_NOT_READY;
    else if (b == SW_DISABLED)    return ST_DISABLED;
    else if (r == SW_READY)       return ST_READY;
    else if (r == SW_SWITCHED_ON) return ST_SWITCHED_ON;
    else if (r == SW_ENABLED)     return ST_ENABLED;
    else if (r == SW_QUICK_STOP)  return ST_QUICK_STOP;
    else                          return ST_NOT_READY;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/cdes_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on cdes_pkg for the payload structs.
`default_nettype none

interface cdes_in_if;
  logic               valid;
  logic               ready;
  cdes_pkg::cdes_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cdes_out_if;
  logic                valid;
  logic                ready;
  cdes_pkg::cdes_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/cdes_step.sv
// One control cycle of the sequencer: statusword decode, fault reset sequencer,
// position lock and target gating, with the state registers. Depends on cdes_pkg.
`default_nettype none

module cdes_step #(
  parameter int POSITION_WIDTH = cdes_pkg::POSITION_WIDTH_DEF,
  parameter int COUNT_WIDTH    = cdes_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  cdes_pkg::cdes_cfg_t cfg_i,
  input  cdes_pkg::cdes_in_t  item_i,
  output cdes_pkg::cdes_out_t res_o
);
  import cdes_pkg::*;

  localparam int CMP_W  = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam int DIST_W = 33;

  cdes_phase_e phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] hold_q, hold_d;
  logic [COUNT_WIDTH-1:0] rec_q, rec_d;
  logic [7:0] att_q, att_d;
  logic was_en_q, was_en_d;
  logic lock_q, lock_d;

  cdes_state_e state;
  logic        send_reset;

  logic signed [POSITION_WIDTH-1:0] act_n;
  logic signed [POSITION_WIDTH-1:0] tgt_n;
  logic signed [POSITION_WIDTH:0]   diff;
  logic [POSITION_WIDTH:0]          gap;
  logic                             near;

  assign state = cdes_decode(item_i.statusword);

  assign act_n = item_i.measured_pos[POSITION_WIDTH-1:0];
  assign tgt_n = item_i.target_position[POSITION_WIDTH-1:0];
  assign diff  = (POSITION_WIDTH+1)'(tgt_n) - (POSITION_WIDTH+1)'(act_n);
  assign gap   = diff[POSITION_WIDTH] ? (POSITION_WIDTH+1)'(-diff)
                                      : (POSITION_WIDTH+1)'(diff);
  assign near  = DIST_W'(gap) <= DIST_W'(cfg_i.lock_threshold);

  // Fault reset sequencer: next phase, counters and attempt count.
  always_comb begin
    cdes_phase_e            ph_c;
    logic [COUNT_WIDTH-1:0] h_c;
    logic [COUNT_WIDTH-1:0] r_c;
    logic [COUNT_WIDTH-1:0] inc;
    logic [7:0]             a_c;
    ph_c = phase_q;
    h_c  = hold_q;
    r_c  = rec_q;
    a_c  = att_q;
    inc  = '0;
    send_reset = 1'b0;
    if (item_i.clear_attempts) begin
      ph_c = PH_IDLE;
      h_c  = '0;
      r_c  = '0;
      a_c  = '0;
    end
    phase_d = ph_c;
    hold_d  = h_c;
    rec_d   = r_c;
    att_d   = a_c;
    if (state != ST_FAULT && state != ST_REACTION) begin
      phase_d = PH_IDLE;
      hold_d  = '0;
      rec_d   = '0;
    end else if (state == ST_FAULT) begin
      if (a_c >= cfg_i.max_reset_attempts) begin
        phase_d = PH_PERM;
      end else begin
        // start a fresh sequence from idle
        if (ph_c == PH_IDLE) begin
          ph_c = PH_HOLD;
          h_c  = '0;
          r_c  = '0;
        end
        phase_d = ph_c;
        hold_d  = h_c;
        rec_d   = r_c;
        unique case (ph_c)
          PH_HOLD: begin
            inc = (h_c == '1) ? h_c : h_c + 1'b1;
            if (CMP_W'(inc) >= CMP_W'(cfg_i.hold_low_cycles)) begin
              phase_d = PH_EDGE;
              hold_d  = '0;
            end else begin
              hold_d = inc;
            end
          end
          PH_EDGE: begin
            att_d      = (a_c == ATTEMPT_MAX) ? a_c : a_c + 8'd1;
            send_reset = 1'b1;
            phase_d    = PH_WAIT;
            rec_d      = '0;
          end
          PH_WAIT: begin
            inc = (r_c == '1) ? r_c : r_c + 1'b1;
            if (CMP_W'(inc) >= CMP_W'(cfg_i.recovery_wait_cycles)) begin
              phase_d = PH_HOLD;
              hold_d  = '0;
              rec_d   = '0;
            end else begin
              rec_d = inc;
            end
          end
          default: begin
            phase_d = ph_c;
          end
        endcase
      end
    end
  end

  // Controlword, lock and target gating.
  always_comb begin
    logic lock_in;
    logic velo_mode;
    lock_in   = was_en_q ? lock_q : 1'b1;
    velo_mode = (cfg_i.target_mode == MODE_CSV) || (cfg_i.target_mode == MODE_CST);
    res_o = '0;
    res_o.safe_position = 32'(act_n);
    lock_d   = 1'b1;
    was_en_d = 1'b0;
    if (state == ST_ENABLED) begin
      was_en_d = 1'b1;
      res_o.controlword = item_i.enable_request ? CW_ENABLE_OP : CW_DISABLE_OP;
      lock_d = lock_in;
      if (velo_mode) begin
        if (was_en_q) begin
          lock_d = 1'b0;
          res_o.safe_velocity = item_i.target_velocity;
          res_o.safe_torque   = item_i.target_torque;
          res_o.operational   = 1'b1;
        end
      end else begin
        if (lock_in && near) begin
          lock_d = 1'b0;
        end
        if (!lock_d) begin
          res_o.safe_position = 32'(tgt_n);
          res_o.safe_velocity = item_i.target_velocity;
          res_o.safe_torque   = item_i.target_torque;
          res_o.operational   = 1'b1;
        end
      end
    end else begin
      unique case (state)
        ST_DISABLED:    res_o.controlword = item_i.enable_request ? CW_SHUTDOWN : CW_ZERO;
        ST_READY:       res_o.controlword =
                          (item_i.enable_request && item_i.reported_mode == cfg_i.target_mode)
                          ? CW_ENABLE_OP : CW_SHUTDOWN;
        ST_SWITCHED_ON: res_o.controlword = item_i.enable_request ? CW_ENABLE_OP : CW_SHUTDOWN;
        ST_QUICK_STOP:  res_o.controlword = CW_VOLTAGE;
        ST_FAULT:       res_o.controlword = send_reset ? CW_RESET : CW_ZERO;
        default:        res_o.controlword = CW_ZERO;
      endcase
    end
    res_o.drive_state     = state;
    res_o.fault_flag      = (state == ST_FAULT) || (state == ST_REACTION);
    res_o.position_locked = lock_d;
    res_o.reset_phase_out = phase_d;
    res_o.attempts_out    = att_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      hold_q   <= '0;
      rec_q    <= '0;
      att_q    <= '0;
      was_en_q <= 1'b0;
      lock_q   <= 1'b1;
    end else if (step_i) begin
      phase_q  <= phase_d;
      hold_q   <= hold_d;
      rec_q    <= rec_d;
      att_q    <= att_d;
      was_en_q <= was_en_d;
      lock_q   <= lock_d;
    end
  end

  a_fault_cw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.fault_flag |-> (res_o.controlword == CW_ZERO || res_o.controlword == CW_RESET))
    else $error("fault state sent a run controlword");

  a_reset_only_in_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.controlword == CW_RESET |-> res_o.drive_state == ST_FAULT)
    else $error("reset edge outside fault state");

  a_oper_unlocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.operational |-> (!res_o.position_locked && res_o.drive_state == ST_ENABLED))
    else $error("targets passed while locked or not enabled");

  a_att_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !item_i.clear_attempts) |=> att_q >= $past(att_q))
    else $error("attempt count dropped without clear");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && state != ST_FAULT && state != ST_REACTION)
      |=> (phase_q == PH_IDLE && hold_q == '0 && rec_q == '0))
    else $error("reset sequence not cleared outside fault");

endmodule

`default_nettype wire

FILE: hdl/cia402_drive_enable_sequencer_top.sv
// CiA 402 drive enable sequencer: each accepted input beat is registered, stepped
// through the sequencer and lands in a result register, so each result passes the
// input register and then the result register, and one beat per clock is sustained
// while the output is ready. Configuration writes take effect on the next clock
// and must only happen while the block is empty. No clearing pass after reset.
// Depends on cdes_pkg, cdes_if and cdes_step.
`default_nettype none

module cia402_drive_enable_sequencer_top #(
  parameter int POSITION_WIDTH = cdes_pkg::POSITION_WIDTH_DEF,
  parameter int COUNT_WIDTH    = cdes_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  cdes_in_if.sink                         in_if,
  cdes_out_if.source                      out_if,
  input  logic                            cfg_we_i,
  input  logic [cdes_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cdes_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import cdes_pkg::*;

  cdes_cfg_t cfg_q;
  logic      in_valid_q, in_valid_d;
  cdes_in_t  in_q;
  logic      out_valid_q, out_valid_d;
  cdes_out_t out_q;
  cdes_out_t res;
  logic      advance;
  logic      in_take;

  // move the held beat into the result register when that slot frees up
  assign advance      = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready  = !in_valid_q || advance;
  assign in_take      = in_if.valid && in_if.ready;
  assign in_valid_d   = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d  = advance ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_q);
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_low_cycles      <= HOLD_LOW_RST;
      cfg_q.recovery_wait_cycles <= RECOVERY_WAIT_RST;
      cfg_q.max_reset_attempts   <= MAX_ATTEMPTS_RST;
      cfg_q.target_mode          <= TARGET_MODE_RST;
      cfg_q.lock_threshold       <= LOCK_THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HOLD_LOW:       cfg_q.hold_low_cycles      <= cfg_data_i[15:0];
        REG_RECOVERY_WAIT:  cfg_q.recovery_wait_cycles <= cfg_data_i[15:0];
        REG_MAX_ATTEMPTS:   cfg_q.max_reset_attempts   <= cfg_data_i[7:0];
        REG_TARGET_MODE:    cfg_q.target_mode          <= cfg_data_i[7:0];
        REG_LOCK_THRESHOLD: cfg_q.lock_threshold       <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_if.data;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  cdes_step #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .cfg_i  (cfg_q),
    .item_i (in_q),
    .res_o  (res)
  );

endmodule

`default_nettype wire
